// File: rtl/rsiema_pkg.sv
package rsiema_pkg;

    localparam int SLOTS      = 4;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int CNT_W      = SLOT_W + 1;
    localparam int AXES       = 3;
    localparam int DATA_W     = 32;
    localparam int VEC_W      = AXES * DATA_W;
    localparam int W_W        = 16;
    localparam int FRAC_W     = 16;
    localparam int SUM_W      = DATA_W + SLOT_W;
    localparam int D_W        = SUM_W + 1;
    localparam int WQ_W       = W_W + 1;
    localparam int KQ_W       = W_W + 2;
    localparam int PN_W       = WQ_W + D_W;
    localparam int PO_W       = KQ_W + DATA_W;
    localparam int T_W        = PN_W + 1;
    localparam int SH_W       = T_W - FRAC_W;
    localparam int DIV_CNT_W  = $clog2(SUM_W + 2);

    localparam logic [W_W-1:0] WEIGHT_RESET = 16'd3277;
    localparam logic [W_W:0]   ONE_Q16      = 17'h1_0000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV,
        ST_RD,
        ST_MUL,
        ST_WR
    } state_t;

    function automatic logic [DATA_W-1:0] sat_floor(input logic signed [T_W-1:0] t);
        logic signed [SH_W-1:0] sh;
        logic                   fits;
        sh   = t[T_W-1:FRAC_W];
        fits = (sh[SH_W-1:DATA_W-1] == '0) || (sh[SH_W-1:DATA_W-1] == '1);
        if (fits)
            return sh[DATA_W-1:0];
        else if (sh[SH_W-1])
            return {1'b1, {(DATA_W-1){1'b0}}};
        else
            return {1'b0, {(DATA_W-1){1'b1}}};
    endfunction

endpackage

// File: rtl/redundant_sensor_inconsistency_ema_unit.sv
// Channel  Dir  Payload (low bit first)
// s_axis   in   tdata: sample_x, sample_y, sample_z; tuser: slot, sensor_active,
//               clear_history; tlast: frame_last
// m_axis   out  tdata: dev_x, dev_y, dev_z; tuser: out_slot, out_active;
//               tlast: out_last
// cfg      in   cfg_data: smoothing_weight
//
// An item without tlast writes its sample to the sample memory; the input stays ready.
// An item with tlast holds the input until the frame is done: a pass over the sample
// memory, a bit-serial divide of the sums by the active count (one quotient bit a
// cycle; skipped with no active slot), then a read, multiply, write-back pass over
// the deviation memory per slot.
// Each result waits in the output register; a stall there holds the write-back step.
// Reset takes effect at once; deviations read as zero until written (valid bits).
module redundant_sensor_inconsistency_ema_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rsiema_pkg::W_W-1:0]       cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [rsiema_pkg::VEC_W-1:0]     s_axis_tdata,  // sample_x, sample_y, sample_z
    input  logic [rsiema_pkg::SLOT_W+1:0]    s_axis_tuser,  // slot, sensor_active, clear_history
    input  logic                             s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [rsiema_pkg::VEC_W-1:0]     m_axis_tdata,  // dev_x, dev_y, dev_z
    output logic [rsiema_pkg::SLOT_W:0]      m_axis_tuser,  // out_slot, out_active
    output logic                             m_axis_tlast
);

    localparam int SLOT_W = rsiema_pkg::SLOT_W;
    localparam int DATA_W = rsiema_pkg::DATA_W;
    localparam int SUM_W  = rsiema_pkg::SUM_W;
    localparam int D_W    = rsiema_pkg::D_W;
    localparam int PN_W   = rsiema_pkg::PN_W;
    localparam int PO_W   = rsiema_pkg::PO_W;
    localparam int T_W    = rsiema_pkg::T_W;
    localparam int CNT_W  = rsiema_pkg::CNT_W;
    localparam int AXES   = rsiema_pkg::AXES;
    localparam int SLOTS  = rsiema_pkg::SLOTS;
    localparam int DC_W   = rsiema_pkg::DIV_CNT_W;

    function automatic logic [rsiema_pkg::W_W:0] ONE_MINUS_W(input logic [rsiema_pkg::W_W-1:0] w);
        return rsiema_pkg::ONE_Q16 - {1'b0, w};
    endfunction

    rsiema_pkg::state_t state_reg, state_next;

    logic [rsiema_pkg::VEC_W-1:0] samp_mem [SLOTS];
    logic [rsiema_pkg::VEC_W-1:0] dev_mem  [SLOTS];
    logic [rsiema_pkg::VEC_W-1:0] samp_rd_reg;
    logic [rsiema_pkg::VEC_W-1:0] dev_rd_reg;
    logic                         dev_rd_vld_reg;

    logic [rsiema_pkg::W_W-1:0]   weight_reg;
    logic [SLOTS-1:0]             mask_reg;
    logic [SLOTS-1:0]             dev_valid_reg;
    logic [CNT_W-1:0]             cnt_reg;
    logic [CNT_W-1:0]             count_reg;
    logic [DC_W-1:0]              div_cnt_reg;

    logic signed [SUM_W-1:0]      sum_reg  [AXES];
    logic [SUM_W-1:0]             quo_reg  [AXES];
    logic [SLOT_W-1:0]            rem_reg  [AXES];
    logic                         neg_reg  [AXES];
    logic signed [SUM_W-1:0]      mean_reg [AXES];

    logic signed [PN_W-1:0]       pnew_reg [AXES];
    logic signed [PO_W-1:0]       pold_reg [AXES];
    logic [DATA_W-1:0]            old_reg  [AXES];
    logic                         act_reg;

    logic                         out_valid_reg;
    logic [rsiema_pkg::VEC_W-1:0] out_data_reg;
    logic [SLOT_W-1:0]            out_slot_reg;
    logic                         out_act_reg;
    logic                         out_last_reg;

    logic                         in_fire;
    logic                         out_load;
    logic [SLOT_W-1:0]            rd_addr;
    logic [SLOT_W-1:0]            in_slot;
    logic [CNT_W-1:0]             prev_cnt;
    logic [rsiema_pkg::VEC_W-1:0] wr_data;

    assign in_slot  = s_axis_tuser[SLOT_W-1:0];
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign rd_addr  = cnt_reg[SLOT_W-1:0];
    assign prev_cnt = cnt_reg - CNT_W'(1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rsiema_pkg::ST_IDLE:
            begin
                if (in_fire && s_axis_tlast)
                    state_next = rsiema_pkg::ST_SUM;
            end
            rsiema_pkg::ST_SUM:
            begin
                if (cnt_reg == CNT_W'(SLOTS))
                begin
                    if (mask_reg != '0)
                        state_next = rsiema_pkg::ST_DIV;
                    else
                        state_next = rsiema_pkg::ST_RD;
                end
            end
            rsiema_pkg::ST_DIV:
            begin
                if (div_cnt_reg == DC_W'(SUM_W + 1))
                    state_next = rsiema_pkg::ST_RD;
            end
            rsiema_pkg::ST_RD:
                state_next = rsiema_pkg::ST_MUL;
            rsiema_pkg::ST_MUL:
                state_next = rsiema_pkg::ST_WR;
            rsiema_pkg::ST_WR:
            begin
                if (out_load)
                begin
                    if (cnt_reg == CNT_W'(SLOTS - 1))
                        state_next = rsiema_pkg::ST_IDLE;
                    else
                        state_next = rsiema_pkg::ST_RD;
                end
            end
            default:
                state_next = rsiema_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        out_load      = 1'b0;
        unique case (state_reg)
            rsiema_pkg::ST_IDLE:
                s_axis_tready = 1'b1;
            rsiema_pkg::ST_WR:
                out_load = !out_valid_reg || m_axis_tready;
            default:
            begin
                s_axis_tready = 1'b0;
                out_load      = 1'b0;
            end
        endcase
    end

    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = {out_act_reg, out_slot_reg};
    assign m_axis_tlast  = out_last_reg;

    // sample and deviation memories
    always_ff @(posedge clk)
    begin
        if (in_fire)
            samp_mem[in_slot] <= s_axis_tdata;
        if (out_load)
            dev_mem[rd_addr] <= wr_data;
        samp_rd_reg    <= samp_mem[rd_addr];
        dev_rd_reg     <= dev_mem[rd_addr];
        dev_rd_vld_reg <= dev_valid_reg[rd_addr];
    end

    // write-back value: updated deviation for active slots, kept value otherwise
    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            if (act_reg)
                wr_data[a*DATA_W +: DATA_W] = rsiema_pkg::sat_floor(
                    T_W'(pnew_reg[a]) + T_W'(pold_reg[a]));
            else
                wr_data[a*DATA_W +: DATA_W] = old_reg[a];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rsiema_pkg::ST_IDLE;
            weight_reg    <= rsiema_pkg::WEIGHT_RESET;
            mask_reg      <= '0;
            dev_valid_reg <= '0;
            cnt_reg       <= '0;
            count_reg     <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                weight_reg <= cfg_data;
            if (in_fire)
            begin
                mask_reg[in_slot] <= s_axis_tuser[SLOT_W];
                if (s_axis_tuser[SLOT_W+1])
                    dev_valid_reg <= '0;
            end
            if (out_load)
                dev_valid_reg[rd_addr] <= 1'b1;

            unique case (state_reg)
                rsiema_pkg::ST_IDLE:
                    cnt_reg <= '0;
                rsiema_pkg::ST_SUM:
                begin
                    if (cnt_reg == CNT_W'(SLOTS))
                    begin
                        cnt_reg   <= '0;
                        count_reg <= CNT_W'($countones(mask_reg));
                    end
                    else
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    div_cnt_reg <= '0;
                end
                rsiema_pkg::ST_DIV:
                    div_cnt_reg <= div_cnt_reg + DC_W'(1);
                rsiema_pkg::ST_WR:
                begin
                    if (out_load)
                        cnt_reg <= cnt_reg + CNT_W'(1);
                end
                default:
                    cnt_reg <= cnt_reg;
            endcase

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        for (int a = 0; a < AXES; a++)
        begin
            logic [CNT_W-1:0]             trial;
            logic signed [D_W-1:0]        d;
            logic signed [rsiema_pkg::WQ_W-1:0] wq;
            logic signed [rsiema_pkg::KQ_W-1:0] kq;
            logic signed [DATA_W-1:0]     old_s;
            logic [DATA_W-1:0]            smp;
            trial = {rem_reg[a], quo_reg[a][SUM_W-1]};
            smp   = samp_rd_reg[a*DATA_W +: DATA_W];
            old_s = dev_rd_vld_reg ? dev_rd_reg[a*DATA_W +: DATA_W] : '0;
            d     = $signed({{(D_W-DATA_W){smp[DATA_W-1]}}, smp})
                  - $signed({mean_reg[a][SUM_W-1], mean_reg[a]});
            wq    = $signed({1'b0, weight_reg});
            kq    = $signed({1'b0, ONE_MINUS_W(weight_reg)});

            unique case (state_reg)
                rsiema_pkg::ST_IDLE:
                    sum_reg[a] <= '0;
                rsiema_pkg::ST_SUM:
                begin
                    if (cnt_reg != '0 && mask_reg[prev_cnt[SLOT_W-1:0]])
                        sum_reg[a] <= sum_reg[a]
                                    + $signed({{(SUM_W-DATA_W){smp[DATA_W-1]}}, smp});
                end
                rsiema_pkg::ST_DIV:
                begin
                    if (div_cnt_reg == '0)
                    begin
                        neg_reg[a] <= sum_reg[a][SUM_W-1];
                        quo_reg[a] <= sum_reg[a][SUM_W-1] ? SUM_W'(-sum_reg[a])
                                                          : SUM_W'(sum_reg[a]);
                        rem_reg[a] <= '0;
                    end
                    else if (div_cnt_reg <= DC_W'(SUM_W))
                    begin
                        if (trial >= count_reg)
                        begin
                            rem_reg[a] <= SLOT_W'(trial - count_reg);
                            quo_reg[a] <= {quo_reg[a][SUM_W-2:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg[a] <= trial[SLOT_W-1:0];
                            quo_reg[a] <= {quo_reg[a][SUM_W-2:0], 1'b0};
                        end
                    end
                    else
                        mean_reg[a] <= neg_reg[a] ? -$signed(quo_reg[a]) : $signed(quo_reg[a]);
                end
                rsiema_pkg::ST_MUL:
                begin
                    pnew_reg[a] <= wq * d;
                    pold_reg[a] <= kq * old_s;
                    old_reg[a]  <= old_s;
                end
                default:
                    sum_reg[a] <= sum_reg[a];
            endcase
        end

        if (state_reg == rsiema_pkg::ST_MUL)
            act_reg <= (count_reg != '0) && mask_reg[rd_addr];

        if (out_load)
        begin
            out_data_reg <= wr_data;
            out_slot_reg <= rd_addr;
            out_act_reg  <= act_reg;
            out_last_reg <= (cnt_reg == CNT_W'(SLOTS - 1));
        end
    end

    a_last_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser[SLOT_W-1:0] == SLOT_W'(SLOTS - 1)))
        else $error("last result not on the highest slot");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rsiema_pkg::ST_DIV) |-> (count_reg != '0))
        else $error("divide started with no active slot");

    a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> (state_reg == rsiema_pkg::ST_SUM))
        else $error("frame end did not start the sum pass");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && out_valid_reg) |-> m_axis_tready)
        else $error("pending result overwritten");

endmodule
